FILE: hw/rtl/stepper_half_step_homing_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a condition and a consequence, clocked on clk
// and disabled while arst_n is low.
`ifndef STEPPER_HALF_STEP_HOMING_MACROS_SVH
`define STEPPER_HALF_STEP_HOMING_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define SHSH_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("stepper checker: same-cycle property failed");

// The consequence must hold in the cycle after the condition.
`define SHSH_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("stepper checker: next-cycle property failed");

`endif

FILE: hw/rtl/shsh_pkg.sv
`default_nettype none

package shsh_pkg;

	// Width of the cycle and span counters.
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Reset value of the tick register.
	localparam logic [7:0] TICKS_RESET = 8'd10;

	// Request codes.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_LEFT  = 2'd1;
	localparam logic [1:0] ACT_RIGHT = 2'd2;
	localparam logic [1:0] ACT_HOME  = 2'd3;

	// Direction codes.
	localparam logic DIR_LEFT  = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_MOVE,
		MODE_BACKOFF,
		MODE_SEEK_LEFT,
		MODE_SEEK_RIGHT
	} mode_t;

	// One input request.
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] cycle_count;
		logic        limit_left;
		logic        limit_right;
	} item_t;

	// One result.
	typedef struct packed {
		logic [3:0]  coils;
		logic        busy;
		logic [15:0] span;
		logic        done;
	} result_t;

	// Half-step winding pattern; right runs the left sequence backwards.
	function automatic logic [3:0] pattern(input logic dir, input logic [2:0] idx);
		logic [2:0] k;
		logic [3:0] p;
		k = (dir == DIR_RIGHT) ? 3'(3'd7 - idx) : idx;
		case (k)
			3'd0: p = 4'h9;
			3'd1: p = 4'h8;
			3'd2: p = 4'hA;
			3'd3: p = 4'h2;
			3'd4: p = 4'h6;
			3'd5: p = 4'h4;
			3'd6: p = 4'h5;
			3'd7: p = 4'h1;
			default: p = 4'h0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shsh_in_stage.sv
`default_nettype none

module shsh_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire shsh_pkg::item_t in_item,
	input  wire logic            space,
	output logic                 fire,
	output shsh_pkg::item_t      item_s1
);

	logic valid_s1;

	// The held request moves on whenever the result register has room.
	assign fire     = valid_s1 & space;
	assign in_ready = ~valid_s1 | space;

	// Occupancy of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/shsh_step.sv
`default_nettype none

module shsh_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_data,
	input  wire logic            fire,
	input  wire shsh_pkg::item_t item_s1,
	output shsh_pkg::result_t    res
);

	shsh_pkg::mode_t               mode_q, mode_d;
	logic                          dir_q, dir_d;
	logic [2:0]                    pidx_q, pidx_d;
	logic [7:0]                    tcnt_q, tcnt_d;
	logic [shsh_pkg::CNT_W-1:0]    cl_q, cl_d;
	logic [shsh_pkg::CNT_W-1:0]    span_q, span_d;
	logic                          lf_q, lf_d;
	logic                          rf_q, rf_d;
	logic [3:0]                    coil_q, coil_d;
	logic [7:0]                    hst_q;
	logic [3:0]                    shown;
	logic                          done;

	// Tick register, written through the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_q <= shsh_pkg::TICKS_RESET;
		end else if (cfg_we) begin
			hst_q <= cfg_data;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= shsh_pkg::MODE_IDLE;
			dir_q  <= shsh_pkg::DIR_LEFT;
			pidx_q <= '0;
			tcnt_q <= '0;
			cl_q   <= '0;
			span_q <= '0;
			lf_q   <= 1'b0;
			rf_q   <= 1'b0;
			coil_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			dir_q  <= dir_d;
			pidx_q <= pidx_d;
			tcnt_q <= tcnt_d;
			cl_q   <= cl_d;
			span_q <= span_d;
			lf_q   <= lf_d;
			rf_q   <= rf_d;
			coil_q <= coil_d;
		end
	end

	// Next state and result for the request in the input register.
	always_comb begin
		logic       run;
		logic       tested;
		logic [7:0] limit;
		logic [7:0] tnext;
		mode_d = mode_q;
		dir_d  = dir_q;
		pidx_d = pidx_q;
		tcnt_d = tcnt_q;
		cl_d   = cl_q;
		span_d = span_q;
		lf_d   = lf_q;
		rf_d   = rf_q;
		coil_d = coil_q;
		shown  = coil_q;
		done   = 1'b0;
		run    = 1'b1;
		tested = 1'b0;
		limit  = (hst_q == 8'd0) ? 8'd1 : hst_q;
		tnext  = tcnt_q + 8'd1;

		if (item_s1.action != shsh_pkg::ACT_TICK) begin
			// A command starts only from idle and clears its own limit flag.
			if (mode_q == shsh_pkg::MODE_IDLE) begin
				pidx_d = '0;
				tcnt_d = '0;
				if (item_s1.action == shsh_pkg::ACT_HOME) begin
					mode_d = shsh_pkg::MODE_SEEK_LEFT;
					dir_d  = shsh_pkg::DIR_LEFT;
					lf_d   = 1'b0;
				end else begin
					dir_d = (item_s1.action == shsh_pkg::ACT_RIGHT);
					if (dir_d == shsh_pkg::DIR_RIGHT) begin
						rf_d = 1'b0;
					end else begin
						lf_d = 1'b0;
					end
					cl_d = shsh_pkg::CNT_W'(item_s1.cycle_count);
					if (cl_d == '0) begin
						done = 1'b1;
					end else begin
						mode_d = shsh_pkg::MODE_MOVE;
					end
				end
			end
			lf_d = lf_d | item_s1.limit_left;
			rf_d = rf_d | item_s1.limit_right;
		end else begin
			lf_d = lf_d | item_s1.limit_left;
			rf_d = rf_d | item_s1.limit_right;
			if (mode_q != shsh_pkg::MODE_IDLE) begin
				// Tests made on the first tick of a cycle.
				if (pidx_q == 3'd0 && tcnt_q == 8'd0) begin
					if (mode_d == shsh_pkg::MODE_SEEK_LEFT) begin
						if (!lf_d) begin
							tested = 1'b1;
						end else begin
							mode_d = shsh_pkg::MODE_SEEK_RIGHT;
							dir_d  = shsh_pkg::DIR_RIGHT;
							rf_d   = 1'b0;
							span_d = '0;
						end
					end
					if (!tested && mode_d == shsh_pkg::MODE_SEEK_RIGHT) begin
						if (!rf_d) begin
							if (span_d != shsh_pkg::CNT_MAX) begin
								span_d = span_d + 1'b1;
							end
							tested = 1'b1;
						end else begin
							mode_d = shsh_pkg::MODE_MOVE;
							dir_d  = shsh_pkg::DIR_LEFT;
							lf_d   = 1'b0;
							cl_d   = span_d >> 1;
							if (cl_d == '0) begin
								mode_d = shsh_pkg::MODE_IDLE;
								done   = 1'b1;
								run    = 1'b0;
								tested = 1'b1;
							end
						end
					end
					if (!tested && mode_d == shsh_pkg::MODE_MOVE) begin
						if ((dir_d == shsh_pkg::DIR_RIGHT) ? rf_d : lf_d) begin
							// Limit hit: one back-off cycle the other way.
							mode_d = shsh_pkg::MODE_BACKOFF;
							dir_d  = ~dir_d;
							if (dir_d == shsh_pkg::DIR_RIGHT) begin
								rf_d = 1'b0;
							end else begin
								lf_d = 1'b0;
							end
							cl_d = '0;
						end else begin
							cl_d = cl_d - 1'b1;
						end
					end
				end
				// Tick counting and pattern output.
				if (run) begin
					tcnt_d = tnext;
					if (tnext >= limit) begin
						tcnt_d = '0;
						shown  = shsh_pkg::pattern(dir_d, pidx_q);
						coil_d = shown;
						if (pidx_q == 3'd7) begin
							pidx_d = '0;
							coil_d = '0;
							if (mode_d == shsh_pkg::MODE_BACKOFF ||
							    (mode_d == shsh_pkg::MODE_MOVE && cl_d == '0)) begin
								mode_d = shsh_pkg::MODE_IDLE;
								done   = 1'b1;
							end
						end else begin
							pidx_d = pidx_q + 3'd1;
						end
					end
				end
			end
		end

		res.coils = shown;
		res.busy  = (mode_d != shsh_pkg::MODE_IDLE);
		res.span  = 16'(span_d);
		res.done  = done;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/shsh_out_stage.sv
`default_nettype none

module shsh_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire shsh_pkg::result_t res,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output shsh_pkg::result_t      res_q
);

	// Room for a new result when empty or when the current one is taken.
	assign space = ~out_valid | out_ready;

	// Occupancy of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= load;
		end
	end

	// Payload of the result register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/stepper_half_step_homing.sv
// Half-step stepper sequencer with homing.
// Input channel (in_valid/in_ready) carries one request per item: a tick,
// a move left or right of cycle_count eight-pattern cycles, or a homing
// run, together with the limit switch edges seen with that request.
// Output channel (out_valid/out_ready) returns exactly one result per
// request: the winding drive, busy, the span counted in the last right
// seek, and a done pulse on the request that finishes an operation.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number of
// ticks per half step; it is always ready, and the user must write it
// only while idle, which the block itself does not enforce. A request
// passes an input register and then a result register before its result
// is offered. Throughput: one request per cycle while out_ready is high;
// each request's work is a single pass of logic between the two registers.
// Reset clears both registers' valid flags, stops any operation, turns
// all windings off and loads the tick register with ten.
// A stalled receiver holds the result register; one more request is held
// in the input register, and in_ready then falls until out_ready returns.
`default_nettype none

module stepper_half_step_homing (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] cycle_count,
	input  wire logic        limit_left,
	input  wire logic        limit_right,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       coils,
	output logic             busy_res,
	output logic [15:0]      span,
	output logic             done_res
);

	shsh_pkg::item_t   in_item;
	shsh_pkg::item_t   item_s1;
	shsh_pkg::result_t res;
	shsh_pkg::result_t res_q;
	logic              space;
	logic              fire;

	// The tick register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	// Gather the request fields.
	assign in_item = '{
		action:      action,
		cycle_count: cycle_count,
		limit_left:  limit_left,
		limit_right: limit_right
	};

	shsh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.space    (space),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	shsh_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.fire     (fire),
		.item_s1  (item_s1),
		.res      (res)
	);

	shsh_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// Spread the result onto its ports.
	assign coils    = res_q.coils;
	assign busy_res = res_q.busy;
	assign span     = res_q.span;
	assign done_res = res_q.done;

endmodule

`default_nettype wire

FILE: hw/rtl/shsh_checker.sv
`default_nettype none

`include "stepper_half_step_homing_macros.svh"

module shsh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  coils,
	input wire logic        busy_res,
	input wire logic [15:0] span,
	input wire logic        done_res
);

	logic [21:0] res_bits;

	// All result fields side by side.
	assign res_bits = {coils, busy_res, span, done_res};

	// A stalled result keeps its value.
	`SHSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_bits))

	// A finishing result always reports the block idle.
	`SHSH_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res)

	// With the result register empty, a request can always be taken.
	`SHSH_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

	// The tick register never refuses a write.
	`SHSH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind stepper_half_step_homing shsh_checker u_shsh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.coils     (coils),
	.busy_res  (busy_res),
	.span      (span),
	.done_res  (done_res)
);

`default_nettype wire
